/* rtl/sawc_pkg.sv */
// Shared types and constants of the size-aware LRU write-back cache.
// No dependencies; every other file of the block imports this package.
package sawc_pkg;

  localparam int unsigned SAWC_ENTRIES  = 16;
  localparam logic [31:0] SAWC_CAP_INIT = 32'd65536;

  localparam logic [1:0] FUNC_GET   = 2'd0;
  localparam logic [1:0] FUNC_PUT   = 2'd1;
  localparam logic [1:0] FUNC_FLUSH = 2'd2;

  localparam logic RK_DONE   = 1'b0;
  localparam logic RK_REPORT = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] item_key;
    logic [31:0] item_size;
  } req_t;

  typedef struct packed {
    logic        result_kind;
    logic        was_hit;
    logic        too_large;
    logic [63:0] entry_key;
    logic [31:0] entry_size;
    logic        needs_writeback;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [63:0] tag;
    logic [31:0] bytes;
    logic        dirty;
    logic [31:0] stamp;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LOOK,
    S_ROOM,
    S_FLUSH,
    S_DONE
  } state_t;

endpackage

/* rtl/sawc_req_if.sv */
// Request channel: valid/ready handshake carrying one request transaction.
// Depends on sawc_pkg.
interface sawc_req_if import sawc_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/sawc_rsp_if.sv */
// Result channel: valid/ready handshake carrying one result transaction.
// Depends on sawc_pkg.
interface sawc_rsp_if import sawc_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/sawc_table.sv */
// Entry table: valid bits in flops, record fields in a register array,
// one write port, one stamp update port and one read port. Depends on sawc_pkg.
module sawc_table import sawc_pkg::*; #(
  parameter int unsigned ENTRIES = SAWC_ENTRIES,
  parameter int unsigned IDXW    = $clog2(ENTRIES)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            clr,
  input  logic            wr_en,
  input  logic [IDXW-1:0] wr_idx,
  input  entry_t          wr_data,
  input  logic            inv_en,
  input  logic [IDXW-1:0] inv_idx,
  input  logic            stamp_en,
  input  logic [IDXW-1:0] stamp_idx,
  input  logic [31:0]     stamp_val,
  input  logic [IDXW-1:0] rd_idx,
  output logic            rd_vld,
  output entry_t          rd_data
);

  logic [ENTRIES-1:0] vld;
  entry_t             mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      vld <= '0;
    end else begin
      if (inv_en) begin
        vld[inv_idx] <= 1'b0;
      end
      if (wr_en) begin
        vld[wr_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (stamp_en) begin
      mem[stamp_idx].stamp <= stamp_val;
    end
  end

  assign rd_vld  = vld[rd_idx];
  assign rd_data = mem[rd_idx];

endmodule

/* rtl/sawc_scan.sv */
// Shared compare unit: one entry per cycle, tracks key match, first free slot
// and oldest entry by age. Restarts at index zero. Depends on sawc_pkg.
module sawc_scan import sawc_pkg::*; #(
  parameter int unsigned IDXW = 4
) (
  input  logic            clk,
  input  logic            en,
  input  logic [IDXW-1:0] idx,
  input  logic            rd_vld,
  input  entry_t          rd_data,
  input  logic [63:0]     key,
  input  logic [31:0]     counter,
  output logic            match_found,
  output logic [IDXW-1:0] match_idx,
  output logic            free_found,
  output logic [IDXW-1:0] free_idx,
  output logic            old_found,
  output logic [IDXW-1:0] old_idx
);

  logic        first;
  logic        m_f;
  logic        f_f;
  logic        o_f;
  logic [31:0] age;
  logic [31:0] old_age;

  assign first = (idx == '0);
  assign m_f   = first ? 1'b0 : match_found;
  assign f_f   = first ? 1'b0 : free_found;
  assign o_f   = first ? 1'b0 : old_found;
  assign age   = counter - rd_data.stamp;

  always_ff @(posedge clk) begin
    if (en) begin
      match_found <= m_f;
      free_found  <= f_f;
      old_found   <= o_f;
      if (rd_vld && !m_f && rd_data.tag == key) begin
        match_found <= 1'b1;
        match_idx   <= idx;
      end
      if (!rd_vld && !f_f) begin
        free_found <= 1'b1;
        free_idx   <= idx;
      end
      if (rd_vld && (!o_f || age > old_age)) begin
        old_found <= 1'b1;
        old_idx   <= idx;
        old_age   <= age;
      end
    end
  end

endmodule

/* rtl/size_aware_lru_writeback_cache.sv */
// Size-aware LRU write-back cache, top level: sequencer, byte budget and
// result register. Depends on sawc_pkg, sawc_req_if, sawc_rsp_if, sawc_table, sawc_scan.
//
// Usage:
//   req carries one request transaction (get, put, flush) with key and size.
//   rsp carries zero or more eviction/flush reports and then one completion
//   with last set. cfg_we/cfg_wdata write the byte capacity and empty the table.
// Sequence:
//   Each pass scans the table one entry per cycle through the shared compare
//   unit. A hit or an oversized record completes after one pass; a miss that
//   fits after one pass and a room check, plus one pass per eviction; a put that
//   replaces a key adds one more pass. A flush steps through the entries and
//   waits on each stalled report.
//   One request is in work at a time; req.ready is high only in idle.
// Reset:
//   Table empty, capacity 65536, recency counter zero, no result pending.
// Stall:
//   A stalled result holds in the output register and the sequencer waits;
//   a new request may be taken while the final completion still waits.
module size_aware_lru_writeback_cache import sawc_pkg::*; #(
  parameter int unsigned ENTRIES = SAWC_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  sawc_req_if.sink    req,
  sawc_rsp_if.source  rsp
);

  localparam int unsigned IDXW = $clog2(ENTRIES);
  localparam logic [IDXW-1:0] IDX_LAST = IDXW'(ENTRIES - 1);

  state_t state, state_next;

  req_t            req_q;
  logic [31:0]     cap;
  logic [31:0]     free_bytes;
  logic [31:0]     counter;
  logic [IDXW-1:0] idx;
  logic            room_phase;
  logic            hit_q;
  logic            big_q;
  logic [IDXW-1:0] slot;
  logic            slot_have;
  logic            rsp_v;
  rsp_t            rsp_d;

  logic            req_fire;
  logic            out_free;
  logic            too_big;
  logic            idx_last;
  logic            is_get;

  logic            scan_en;
  logic            idx_inc;
  logic [IDXW-1:0] rd_idx;
  logic            rd_vld;
  entry_t          rd_data;
  logic            wr_en;
  logic [IDXW-1:0] wr_idx;
  entry_t          wr_data;
  logic            inv_en;
  logic [IDXW-1:0] inv_idx;
  logic            stamp_en;
  logic            cnt_inc;
  logic            free_add;
  logic            free_sub;
  logic            tbl_clr;
  logic            flush_end;
  logic            emit;
  rsp_t            emit_data;

  logic            match_found;
  logic [IDXW-1:0] match_idx;
  logic            free_found;
  logic [IDXW-1:0] free_idx;
  logic            old_found;
  logic [IDXW-1:0] old_idx;

  logic            have_eff;
  logic [IDXW-1:0] slot_eff;
  logic            evict;

  assign req_fire = req.valid && req.ready;
  assign out_free = !rsp_v || rsp.ready;
  assign too_big  = req_q.item_size > cap;
  assign idx_last = (idx == IDX_LAST);
  assign is_get   = (req_q.func == FUNC_GET);
  assign have_eff = slot_have || free_found;
  assign slot_eff = slot_have ? slot : (free_found ? free_idx : old_idx);
  assign evict    = ((free_bytes < req_q.item_size) || !have_eff) && old_found;

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = rsp_v;
  assign rsp.data  = rsp_d;

  sawc_table #(.ENTRIES(ENTRIES), .IDXW(IDXW)) u_table (
    .clk       (clk),
    .rst       (rst),
    .clr       (tbl_clr),
    .wr_en     (wr_en),
    .wr_idx    (wr_idx),
    .wr_data   (wr_data),
    .inv_en    (inv_en),
    .inv_idx   (inv_idx),
    .stamp_en  (stamp_en),
    .stamp_idx (match_idx),
    .stamp_val (counter),
    .rd_idx    (rd_idx),
    .rd_vld    (rd_vld),
    .rd_data   (rd_data)
  );

  sawc_scan #(.IDXW(IDXW)) u_scan (
    .clk         (clk),
    .en          (scan_en),
    .idx         (idx),
    .rd_vld      (rd_vld),
    .rd_data     (rd_data),
    .key         (req_q.item_key),
    .counter     (counter),
    .match_found (match_found),
    .match_idx   (match_idx),
    .free_found  (free_found),
    .free_idx    (free_idx),
    .old_found   (old_found),
    .old_idx     (old_idx)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_fire) begin
          if (req.data.func == FUNC_GET || req.data.func == FUNC_PUT) begin
            state_next = S_SCAN;
          end else if (req.data.func == FUNC_FLUSH) begin
            state_next = S_FLUSH;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (idx_last) begin
          state_next = room_phase ? S_ROOM : S_LOOK;
        end
      end
      S_LOOK: begin
        if (match_found) begin
          state_next = (is_get || too_big) ? S_DONE : S_SCAN;
        end else begin
          state_next = too_big ? S_DONE : S_ROOM;
        end
      end
      S_ROOM: begin
        if (!evict) begin
          state_next = S_DONE;
        end else if (out_free) begin
          state_next = S_SCAN;
        end
      end
      S_FLUSH: begin
        if (idx_inc && idx_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    scan_en   = 1'b0;
    idx_inc   = 1'b0;
    rd_idx    = idx;
    wr_en     = 1'b0;
    wr_idx    = slot_eff;
    wr_data   = '{tag: req_q.item_key, bytes: req_q.item_size,
                  dirty: !is_get, stamp: counter};
    inv_en    = 1'b0;
    inv_idx   = old_idx;
    stamp_en  = 1'b0;
    cnt_inc   = 1'b0;
    free_add  = 1'b0;
    free_sub  = 1'b0;
    flush_end = 1'b0;
    emit      = 1'b0;
    emit_data = '0;
    unique case (state)
      S_IDLE: ;
      S_SCAN: begin
        scan_en = 1'b1;
        idx_inc = 1'b1;
      end
      S_LOOK: begin
        rd_idx = match_idx;
        if (match_found) begin
          if (is_get) begin
            stamp_en = 1'b1;
            cnt_inc  = 1'b1;
          end else begin
            inv_en   = 1'b1;
            inv_idx  = match_idx;
            free_add = 1'b1;
          end
        end
      end
      S_ROOM: begin
        rd_idx = old_idx;
        if (evict) begin
          if (out_free) begin
            emit                      = 1'b1;
            emit_data.result_kind     = RK_REPORT;
            emit_data.entry_key       = rd_data.tag;
            emit_data.entry_size      = rd_data.bytes;
            emit_data.needs_writeback = rd_data.dirty;
            inv_en                    = 1'b1;
            free_add                  = 1'b1;
          end
        end else if (have_eff) begin
          wr_en    = 1'b1;
          cnt_inc  = 1'b1;
          free_sub = 1'b1;
        end
      end
      S_FLUSH: begin
        if (rd_vld && rd_data.dirty) begin
          if (out_free) begin
            emit                      = 1'b1;
            emit_data.result_kind     = RK_REPORT;
            emit_data.entry_key       = rd_data.tag;
            emit_data.entry_size      = rd_data.bytes;
            emit_data.needs_writeback = 1'b1;
            idx_inc                   = 1'b1;
          end
        end else begin
          idx_inc = 1'b1;
        end
        flush_end = idx_inc && idx_last;
      end
      S_DONE: begin
        if (out_free) begin
          emit                  = 1'b1;
          emit_data.result_kind = RK_DONE;
          emit_data.was_hit     = hit_q;
          emit_data.too_large   = big_q;
          emit_data.last        = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign tbl_clr = flush_end || cfg_we;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cap        <= SAWC_CAP_INIT;
      free_bytes <= SAWC_CAP_INIT;
      counter    <= '0;
      idx        <= '0;
      room_phase <= 1'b0;
      hit_q      <= 1'b0;
      big_q      <= 1'b0;
      slot_have  <= 1'b0;
      rsp_v      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        cap        <= cfg_wdata;
        free_bytes <= cfg_wdata;
      end else if (flush_end) begin
        free_bytes <= cap;
      end else if (free_add) begin
        free_bytes <= free_bytes + rd_data.bytes;
      end else if (free_sub) begin
        free_bytes <= free_bytes - req_q.item_size;
      end
      if (cnt_inc) begin
        counter <= counter + 32'd1;
      end
      if (req_fire) begin
        idx        <= '0;
        room_phase <= 1'b0;
        hit_q      <= 1'b0;
        big_q      <= 1'b0;
        slot_have  <= 1'b0;
      end else if (idx_inc) begin
        idx <= idx_last ? '0 : idx + 1'b1;
      end
      if (state == S_LOOK) begin
        room_phase <= 1'b1;
        hit_q      <= match_found;
        big_q      <= too_big && !(match_found && is_get);
      end
      if (state == S_ROOM && evict && out_free) begin
        slot_have <= 1'b1;
      end
      if (emit) begin
        rsp_v <= 1'b1;
      end else if (rsp.ready) begin
        rsp_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      req_q <= req.data;
    end
    if (state == S_ROOM && evict && out_free) begin
      slot <= slot_eff;
    end
    if (emit) begin
      rsp_d <= emit_data;
    end
  end

endmodule

/* rtl/sawc_checker.sv */
// Port-level checks of the cache top level, attached by bind.
// Depends on sawc_pkg and size_aware_lru_writeback_cache.
module sawc_checker import sawc_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp_data
);

  logic [1:0] open_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_cnt <= '0;
    end else begin
      open_cnt <= open_cnt + 2'(req_valid && req_ready)
                  - 2'(rsp_valid && rsp_ready && rsp_data.last);
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result changed while stalled");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> open_cnt != 2'd0)
    else $error("result without an open request");

  a_one_open: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> open_cnt == 2'd0 || (open_cnt == 2'd1 && rsp_valid && rsp_data.last))
    else $error("request taken while another is in work");

  a_report_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.result_kind == RK_REPORT
      |-> !rsp_data.last && !rsp_data.was_hit && !rsp_data.too_large)
    else $error("report carries completion flags");

endmodule

bind size_aware_lru_writeback_cache sawc_checker u_sawc_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);

/* test/sawc_tb_if.sv */
`timescale 1ns / 100ps
// Testbench-side note: the block's own interfaces sawc_req_if and sawc_rsp_if
// are reused as they are; this file only holds the scoreboard package.
package sawc_tb_pkg;
  import sawc_pkg::*;

  class cache_scoreboard;
    logic [31:0] capacity;
    logic [31:0] free_bytes;
    logic [31:0] recency;
    bit          ent_valid [SAWC_ENTRIES];
    logic [63:0] ent_tag   [SAWC_ENTRIES];
    logic [31:0] ent_bytes [SAWC_ENTRIES];
    bit          ent_dirty [SAWC_ENTRIES];
    logic [31:0] ent_stamp [SAWC_ENTRIES];
    rsp_t        pending_results[$];
    int          errors;

    function void clear_table();
      foreach (ent_valid[i]) ent_valid[i] = 0;
      free_bytes = capacity;
    endfunction

    function void reset_state();
      capacity = SAWC_CAP_INIT;
      recency = 0;
      errors = 0;
      pending_results.delete();
      clear_table();
    endfunction

    function void set_capacity(logic [31:0] cap);
      capacity = cap;
      clear_table();
    endfunction

    function void push_result(bit kind, bit hit, bit big, logic [63:0] key,
                              logic [31:0] size, bit wb, bit fin);
      rsp_t r;
      r.result_kind = kind;
      r.was_hit = hit;
      r.too_large = big;
      r.entry_key = key;
      r.entry_size = size;
      r.needs_writeback = wb;
      r.last = fin;
      pending_results.push_back(r);
    endfunction

    function int find_key(logic [63:0] key);
      for (int i = 0; i < SAWC_ENTRIES; i++)
        if (ent_valid[i] && ent_tag[i] == key) return i;
      return -1;
    endfunction

    function int find_oldest();
      int best;
      logic [31:0] best_age, age;
      best = -1;
      best_age = 0;
      for (int i = 0; i < SAWC_ENTRIES; i++)
        if (ent_valid[i]) begin
          age = recency - ent_stamp[i];
          if (best < 0 || age > best_age) begin
            best = i;
            best_age = age;
          end
        end
      return best;
    endfunction

    function void drop_entry(int i);
      ent_valid[i] = 0;
      free_bytes = free_bytes + ent_bytes[i];
    endfunction

    function void insert_record(logic [63:0] key, logic [31:0] size, bit dirty);
      int slot, v;
      slot = -1;
      for (int i = SAWC_ENTRIES - 1; i >= 0; i--)
        if (!ent_valid[i]) slot = i;
      while (free_bytes < size || slot < 0) begin
        v = find_oldest();
        if (v < 0) break;
        push_result(RK_REPORT, 0, 0, ent_tag[v], ent_bytes[v], ent_dirty[v], 0);
        drop_entry(v);
        if (slot < 0) slot = v;
      end
      if (slot >= 0) begin
        ent_valid[slot] = 1;
        ent_tag[slot] = key;
        ent_bytes[slot] = size;
        ent_dirty[slot] = dirty;
        ent_stamp[slot] = recency;
        recency = recency + 1;
        free_bytes = free_bytes - size;
      end
    endfunction

    function void note_request(req_t rq);
      int i;
      bit hit;
      case (rq.func)
        FUNC_GET: begin
          i = find_key(rq.item_key);
          if (i >= 0) begin
            ent_stamp[i] = recency;
            recency = recency + 1;
            push_result(RK_DONE, 1, 0, 0, 0, 0, 1);
          end else if (rq.item_size > capacity) begin
            push_result(RK_DONE, 0, 1, 0, 0, 0, 1);
          end else begin
            insert_record(rq.item_key, rq.item_size, 0);
            push_result(RK_DONE, 0, 0, 0, 0, 0, 1);
          end
        end
        FUNC_PUT: begin
          i = find_key(rq.item_key);
          hit = (i >= 0);
          if (hit) drop_entry(i);
          if (rq.item_size > capacity) begin
            push_result(RK_DONE, hit, 1, 0, 0, 0, 1);
          end else begin
            insert_record(rq.item_key, rq.item_size, 1);
            push_result(RK_DONE, hit, 0, 0, 0, 0, 1);
          end
        end
        FUNC_FLUSH: begin
          for (int j = 0; j < SAWC_ENTRIES; j++)
            if (ent_valid[j] && ent_dirty[j])
              push_result(RK_REPORT, 0, 0, ent_tag[j], ent_bytes[j], 1, 0);
          clear_table();
          push_result(RK_DONE, 0, 0, 0, 0, 0, 1);
        end
        default: push_result(RK_DONE, 0, 0, 0, 0, 0, 1);
      endcase
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_result(rsp_t got);
      rsp_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      want = pending_results.pop_front();
      if (got.result_kind !== want.result_kind) report("result_kind");
      if (got.was_hit !== want.was_hit) report("was_hit");
      if (got.too_large !== want.too_large) report("too_large");
      if (got.entry_key !== want.entry_key)
        report($sformatf("entry_key %h want %h", got.entry_key, want.entry_key));
      if (got.entry_size !== want.entry_size)
        report($sformatf("entry_size %h want %h", got.entry_size, want.entry_size));
      if (got.needs_writeback !== want.needs_writeback) report("needs_writeback");
      if (got.last !== want.last) report("last");
    endtask
  endclass
endpackage

/* test/testbench.sv */
`timescale 1ns / 100ps
// Top of the cache testbench: drives requests and capacity writes, checks
// every result against the scoreboard. Depends on sawc_pkg and sawc_tb_pkg.
module testbench;
  import sawc_pkg::*;
  import sawc_tb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [31:0] cfg_wdata = 0;
  int          cycles = 0;
  bit          quiet = 0;
  int          hold_off = 0;
  logic [63:0] key_pool [8];

  cache_scoreboard board;

  sawc_req_if req ();
  sawc_rsp_if rsp ();

  size_aware_lru_writeback_cache DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req(req), .rsp(rsp)
  );

  initial begin
    req.valid = 0;
    req.data = '0;
    rsp.ready = 0;
  end

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && req.valid && req.ready) board.note_request(req.data);
    if (!rst && rsp.valid && rsp.ready) board.check_result(rsp.data);
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      rsp.ready <= 0;
    end else begin
      rsp.ready <= quiet || ($urandom_range(99) >= 26);
    end
  end

  task automatic send(logic [1:0] f, logic [63:0] k, logic [31:0] s);
    req_t rq;
    rq.func = f;
    rq.item_key = k;
    rq.item_size = s;
    while (!quiet && $urandom_range(99) < 26) begin
      req.valid <= 0;
      @(posedge clk);
    end
    req.valid <= 1;
    req.data <= rq;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic drain();
    req.valid <= 0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_capacity(logic [31:0] cap);
    drain();
    cfg_we <= 1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 0;
    board.set_capacity(cap);
  endtask

  function automatic logic [31:0] rand_size(logic [31:0] cap);
    int r;
    r = $urandom_range(99);
    if (r < 5) return $urandom();
    if (r < 10) return 0;
    if (r < 15) return cap;
    return $urandom_range(cap / 4 + 1);
  endfunction

  task automatic random_phase(int n, logic [31:0] cap);
    int r;
    logic [1:0] f;
    logic [63:0] k;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 45) f = FUNC_GET;
      else if (r < 90) f = FUNC_PUT;
      else if (r < 97) f = FUNC_FLUSH;
      else f = 2'd3;
      if ($urandom_range(9) < 8)
        k = key_pool[$urandom_range(7)] + 64'($urandom_range(20));
      else k = {$urandom(), $urandom()};
      send(f, k, rand_size(cap));
    end
  endtask

  initial begin
    board = new();
    board.reset_state();
    foreach (key_pool[i]) key_pool[i] = {$urandom(), $urandom()};
    key_pool[0] = 64'h0;
    key_pool[1] = 64'hFFFF_FFFF_FFFF_FFD0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send(FUNC_GET, 64'h0, 32'd0);
    send(FUNC_GET, 64'h0, 32'd100);
    send(FUNC_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 32'd65536);
    send(FUNC_PUT, 64'h1, 32'hFFFF_FFFF);
    send(FUNC_GET, 64'h2, 32'd65537);
    send(FUNC_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 32'd70000);
    for (int i = 0; i < 18; i++)
      send(i[0] ? FUNC_PUT : FUNC_GET, 64'h100 + 64'(i), 32'(i * 3));
    send(2'd3, 64'hA5A5_A5A5_5A5A_5A5A, 32'h5A5A_A5A5);
    send(FUNC_FLUSH, 64'h0, 32'd0);

    write_capacity(32'd1);
    quiet = 1;
    random_phase(30, 32'd1);
    quiet = 0;
    write_capacity(32'd300);
    hold_off = 300;
    random_phase(60, 32'd300);
    write_capacity(32'hFFFF_FFFF);
    random_phase(40, 32'hFFFF_FFFF);
    write_capacity(32'd5000);
    random_phase(25, 32'd5000);
    send(FUNC_FLUSH, 64'h0, 32'd0);
    drain();

    if (board.errors == 0 && board.pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
